FILE: sv/assert_macros.svh
// assertion macros shared by the rtl that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked at every rising edge out of reset
`define GFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked at every rising edge out of reset
`define GFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define GFE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define GFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: sv/gfe_pkg.sv
// shared types and constants of the glyph expander
`default_nettype none

package gfe_pkg;

  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned PAIR_W      = 2 * COLOR_W;
  localparam int unsigned GLYPH_W     = 8;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned COL_W       = 2;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  // configuration register indexes
  localparam logic REG_INK_COLOR   = 1'b0;
  localparam logic REG_PAPER_COLOR = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic             write;      // store a font byte
    logic             capture;    // latch a render item and read its first glyph row
    logic             rd_next;    // read the next glyph row
    logic             load_bits;  // take the read glyph row into the pixel register
    logic             next_row;   // step the row base by the pitch
    logic             emit;       // push one word into the output register
    logic             last;       // the word pushed is the last of the character
    logic [COL_W-1:0] col;        // word column within the glyph row
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/gfe_ram.sv
// generic single write port ram with registered read
`default_nettype none

module gfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/gfe_ctrl.sv
// sequencer for font loads and row by row character expansion
`default_nettype none

module gfe_ctrl #(
  parameter int unsigned GLYPH_ROWS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                kind_i,
  output logic                     ready_o,
  input  wire gfe_pkg::dp_status_t status_i,
  output gfe_pkg::dp_cmd_t         cmd_o
);

  import gfe_pkg::*;

  localparam int unsigned RowW = $clog2(GLYPH_ROWS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             row_end;
  logic             last_row;

  assign row_end  = (col_q == COL_W'(3));
  assign last_row = (row_q == RowW'(GLYPH_ROWS - 1));
  assign ready_o  = (state_q == ST_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.col  = col_q;
    cmd_o.last = last_row && row_end;
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == KIND_RENDER) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_LOAD;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        // first glyph row arrives, prefetch the second
        cmd_o.load_bits = 1'b1;
        cmd_o.rd_next   = 1'b1;
        row_d           = '0;
        col_d           = '0;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          col_d      = col_q + COL_W'(1);
          if (row_end) begin
            cmd_o.load_bits = 1'b1;
            cmd_o.rd_next   = 1'b1;
            cmd_o.next_row  = 1'b1;
            row_d           = row_q + RowW'(1);
            if (last_row) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/gfe_datapath.sv
// font store, glyph row register, colour selection and output register
`default_nettype none

module gfe_datapath #(
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned FONT_CHARS = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire gfe_pkg::dp_cmd_t                cmd_i,
  output gfe_pkg::dp_status_t                  status_o,
  input  wire logic [gfe_pkg::ADDR_W-1:0]      glyph_address_i,
  input  wire logic [gfe_pkg::GLYPH_W-1:0]     glyph_byte_i,
  input  wire logic [gfe_pkg::CODE_W-1:0]      char_code_i,
  input  wire logic [gfe_pkg::POS_W-1:0]       char_position_i,
  input  wire logic [gfe_pkg::LEN_W-1:0]       string_length_i,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [gfe_pkg::COLOR_W-1:0]     cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [gfe_pkg::ADDR_W-1:0]      word_offset_o,
  output logic      [gfe_pkg::PAIR_W-1:0]      pixel_pair_o,
  output logic                                 last_word_o
);

  import gfe_pkg::*;

  localparam int unsigned PitchW = LEN_W + 2;

  logic [COLOR_W-1:0] ink_color_q;
  logic [COLOR_W-1:0] paper_color_q;

  logic [ADDR_W-1:0]  addr_q;
  logic [ADDR_W-1:0]  row_base_q;
  logic [PitchW-1:0]  pitch_q;
  logic               code_ok_q;
  logic [GLYPH_W-1:0] bits_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  word_offset_q;
  logic [PAIR_W-1:0]  pixel_pair_q;
  logic               last_word_q;

  logic [ADDR_W-1:0]  glyph_base;
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_en;
  logic [GLYPH_W-1:0] rd_data;
  logic               bit_hi;
  logic               bit_lo;
  logic [COLOR_W-1:0] color_hi;
  logic [COLOR_W-1:0] color_lo;

  // code * rows + row wraps in the store address width
  assign glyph_base = ADDR_W'(char_code_i) * ADDR_W'(GLYPH_ROWS);
  assign rd_en      = cmd_i.capture | cmd_i.rd_next;
  assign rd_addr    = cmd_i.capture ? glyph_base : addr_q;

  gfe_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (STORE_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (glyph_address_i),
    .wdata_i (glyph_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // msb first: column c takes bits 7-2c and 6-2c
  assign bit_hi   = bits_q[{~cmd_i.col, 1'b1}];
  assign bit_lo   = bits_q[{~cmd_i.col, 1'b0}];
  assign color_hi = bit_hi ? ink_color_q : paper_color_q;
  assign color_lo = bit_lo ? ink_color_q : paper_color_q;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_color_q   <= '1;
      paper_color_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_INK_COLOR:   ink_color_q   <= cfg_data_i;
          REG_PAPER_COLOR: paper_color_q <= cfg_data_i;
          default:         ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q     <= glyph_base + ADDR_W'(1);
      row_base_q <= ADDR_W'({char_position_i, 2'b00});
      pitch_q    <= {string_length_i, 2'b00};
      code_ok_q  <= ({1'b0, char_code_i} < (CODE_W + 1)'(FONT_CHARS));
    end else if (cmd_i.rd_next) begin
      addr_q <= addr_q + ADDR_W'(1);
    end
    if (cmd_i.next_row) begin
      row_base_q <= row_base_q + ADDR_W'(pitch_q);
    end
    if (cmd_i.load_bits) begin
      bits_q <= code_ok_q ? rd_data : '0;
    end
    if (cmd_i.emit) begin
      word_offset_q <= row_base_q + ADDR_W'(cmd_i.col);
      pixel_pair_q  <= {color_hi, color_lo};
      last_word_q   <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_offset_o = word_offset_q;
  assign pixel_pair_o  = pixel_pair_q;
  assign last_word_o   = last_word_q;

endmodule

`default_nettype wire

FILE: sv/glyph_to_framebuffer_expander_core.sv
// top level of the 8-pixel-wide bitmap font character generator
`default_nettype none

// Character generator for a 16-bit-colour framebuffer strip. A 4096 x 8 font
// ram is loaded one glyph row per beat (kind 0: glyph_byte at glyph_address);
// a load beat produces no output; the block stays idle. A render beat (kind 1)
// expands one character into 4*GLYPH_ROWS output beats, row by row and then
// left to right, each beat carrying two RGB565 pixels (left pixel in the
// upper half) chosen from the ink colour (register 0) where the glyph bit is
// one and the paper colour (register 1) where it is zero. word_offset is
// row*4*string_length + char_position*4 + column, wrapping at 4096, and
// last_word marks the final beat of the character. Codes at or above
// FONT_CHARS render as all background. Font entries are undefined until
// loaded and there is no clearing pass after reset; render only glyphs that
// were loaded. A render beat runs in steps: the accept step latches the item
// and starts the first font read, the load step takes the first glyph row
// into the pixel register, then one output beat per cycle follows while the
// output is not stalled, the next glyph row being read from the single ram
// read port while the current row streams out. The input is stalled while
// a character is being expanded; once the last beat sits in the output
// register the next item is accepted. Configuration writes take effect at
// once and are meant for idle periods.
module glyph_to_framebuffer_expander_core #(
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned FONT_CHARS = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        kind_i,
  input  wire logic [gfe_pkg::ADDR_W-1:0]  glyph_address_i,
  input  wire logic [gfe_pkg::GLYPH_W-1:0] glyph_byte_i,
  input  wire logic [gfe_pkg::CODE_W-1:0]  char_code_i,
  input  wire logic [gfe_pkg::POS_W-1:0]   char_position_i,
  input  wire logic [gfe_pkg::LEN_W-1:0]   string_length_i,
  // output beats
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [gfe_pkg::ADDR_W-1:0]  word_offset_o,
  output logic      [gfe_pkg::PAIR_W-1:0]  pixel_pair_o,
  output logic                             last_word_o,
  // configuration writes
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [gfe_pkg::COLOR_W-1:0] cfg_data_i
);

  import gfe_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       ready;

  // the controller only looks at input beats while idle
  assign in_stall_o = !ready;

  gfe_ctrl #(
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .ready_o    (ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gfe_datapath #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .FONT_CHARS (FONT_CHARS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .glyph_address_i (glyph_address_i),
    .glyph_byte_i    (glyph_byte_i),
    .char_code_i     (char_code_i),
    .char_position_i (char_position_i),
    .string_length_i (string_length_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .word_offset_o   (word_offset_o),
    .pixel_pair_o    (pixel_pair_o),
    .last_word_o     (last_word_o)
  );

  // an accepted render beat keeps the input stalled in the next cycle
  `GFE_ASSERT_NEXT(a_render_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && kind_i == KIND_RENDER, in_stall_o)

  // row bases are multiples of four, so the last word sits in column three
  `GFE_ASSERT_IMPL(a_last_column, clk_i, rst_ni, out_valid_o && last_word_o, word_offset_o[1:0] == 2'b11)

  // words before the last one only appear while the character is in progress
  `GFE_ASSERT_IMPL(a_mid_char_busy, clk_i, rst_ni, out_valid_o && !last_word_o, in_stall_o)

endmodule

`default_nettype wire

FILE: dv/tb_glyph_to_framebuffer_expander_core.sv
// testbench for the glyph expander: shadow font predictor checked against random load and render beats
`timescale 1ns / 1ps

module tb_glyph_to_framebuffer_expander_core;
  import gfe_pkg::*;

  localparam int unsigned ROWS          = 16;
  localparam int unsigned WORDS_PER_ROW = 4;
  localparam int unsigned HOLD_LEN      = 600;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES  = 100;  // idle time before the final report
  localparam int unsigned SETTLE_CYCLES = 8;    // quiet time after each phase
  localparam int unsigned PHASE_ITEMS   = 52;
  localparam int unsigned PRINT_CAP     = 100;

  // one input beat
  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  addr;
    logic [GLYPH_W-1:0] gbyte;
    logic [CODE_W-1:0]  code;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
  } glyph_req_t;

  // one framebuffer word as the block should emit it
  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [PAIR_W-1:0] pair;
    logic              last;
  } fb_word_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // dut connections, all driven to known values from time zero
  glyph_req_t         offered     = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [ADDR_W-1:0]  word_offset;
  logic [PAIR_W-1:0]  pixel_pair;
  logic               last_word;
  logic               cfg_we      = 1'b0;
  logic               cfg_index   = REG_INK_COLOR;
  logic [COLOR_W-1:0] cfg_data    = '0;

  glyph_to_framebuffer_expander_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (offered.kind),
    .glyph_address_i (offered.addr),
    .glyph_byte_i    (offered.gbyte),
    .char_code_i     (offered.code),
    .char_position_i (offered.pos),
    .string_length_i (offered.len),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .word_offset_o   (word_offset),
    .pixel_pair_o    (pixel_pair),
    .last_word_o     (last_word),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // predictor state: font copy and colour registers as the block should hold them
  logic [GLYPH_W-1:0] font_shadow [STORE_DEPTH];
  logic [COLOR_W-1:0] ink_color   = 16'hFFFF;
  logic [COLOR_W-1:0] paper_color = 16'h0000;
  fb_word_t           words_due [$];

  // stimulus bookkeeping: which font rows hold a known byte by the time a render is queued
  bit                 row_loaded [STORE_DEPTH];
  glyph_req_t         pending_reqs [$];

  // pacing controls; the stimulus process sets the calm flags and hold_arm at the falling edge
  bit                 tx_calm   = 1'b0;
  bit                 rx_calm   = 1'b0;
  bit                 hold_arm  = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        tx_gap    = 0;
  int unsigned        rx_gap    = 0;
  int unsigned        fail_count = 0;

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [COLOR_W-1:0] shade(logic b);
    return b ? ink_color : paper_color;
  endfunction

  // expand one character into its 64 words, row by row, left to right
  function automatic void predict_char_words(glyph_req_t r);
    logic [GLYPH_W-1:0] bits;
    logic [ADDR_W-1:0]  font_addr;
    fb_word_t           w;
    int unsigned        pitch;
    pitch = WORDS_PER_ROW * r.len;
    for (int unsigned row = 0; row < ROWS; row++) begin
      font_addr = ADDR_W'(r.code * ROWS + row);
      bits = font_shadow[font_addr];
      for (int unsigned col = 0; col < WORDS_PER_ROW; col++) begin
        // offset wraps at the 12-bit word range
        w.offset = ADDR_W'(row * pitch + r.pos * WORDS_PER_ROW + col);
        // msb is the leftmost pixel, left pixel in the upper half
        w.pair   = {shade(bits[7 - 2 * col]), shade(bits[6 - 2 * col])};
        w.last   = (row == ROWS - 1) && (col == WORDS_PER_ROW - 1);
        words_due.push_back(w);
      end
    end
  endfunction

  // driver: offers queued beats, updates the predictor on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned g;
    glyph_req_t  nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      g = tx_gap;
      if (in_valid && !in_stall) begin
        if (offered.kind == KIND_LOAD) font_shadow[offered.addr] = offered.gbyte;
        else predict_char_words(offered);
        g = tx_calm ? 0 : $urandom_range(0, 9);
      end
      // payload only moves when nothing is offered or the last beat went through
      if (!in_valid || !in_stall) begin
        if (g != 0 || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (g != 0) g--;
        end else begin
          nxt = pending_reqs.pop_front();
          offered  <= nxt;
          in_valid <= 1'b1;
        end
      end
      tx_gap <= g;
    end
  end

  // long hold-off counter, started by the stimulus process
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_arm = 1'b0;
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compares every accepted output beat with the oldest expected word
  always @(posedge clk_i or negedge rst_ni) begin
    fb_word_t    want;
    int unsigned w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_gap    <= 0;
    end else begin
      w = rx_gap;
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word offset %0d", word_offset));
        end else begin
          want = words_due.pop_front();
          if (word_offset !== want.offset)
            report_mismatch($sformatf("word_offset %0d, want %0d", word_offset, want.offset));
          if (pixel_pair !== want.pair)
            report_mismatch($sformatf("pixel_pair %h, want %h (offset %0d)",
                                      pixel_pair, want.pair, want.offset));
          if (last_word !== want.last)
            report_mismatch($sformatf("last_word %b, want %b (offset %0d)",
                                      last_word, want.last, want.offset));
        end
        w = rx_calm ? 0 : $urandom_range(0, 9);
      end
      out_stall <= (hold_left != 0 || w != 0);
      if (hold_left == 0 && w != 0) w--;
      rx_gap <= w;
    end
  end

  // ---- stimulus helpers, called at the falling edge ----

  function automatic void queue_load(logic [ADDR_W-1:0] addr, logic [GLYPH_W-1:0] gbyte);
    glyph_req_t r;
    r.kind  = KIND_LOAD;
    r.addr  = addr;
    r.gbyte = gbyte;
    // render fields carry noise on a load beat
    r.code  = CODE_W'($urandom);
    r.pos   = POS_W'($urandom);
    r.len   = LEN_W'($urandom);
    row_loaded[addr] = 1'b1;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_render(logic [CODE_W-1:0] code, logic [POS_W-1:0] pos,
                                       logic [LEN_W-1:0] len);
    glyph_req_t r;
    r.kind  = KIND_RENDER;
    r.addr  = ADDR_W'($urandom);
    r.gbyte = GLYPH_W'($urandom);
    r.code  = code;
    r.pos   = pos;
    r.len   = len;
    pending_reqs.push_back(r);
  endfunction

  // mostly well-formed strings, some zero, oversize or out-of-string positions
  function automatic void queue_random_render(logic [CODE_W-1:0] code);
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    if ($urandom_range(0, 99) < 85) begin
      len = LEN_W'($urandom_range(1, 64));
      pos = POS_W'($urandom_range(0, len - 1));
    end else begin
      len = LEN_W'($urandom_range(0, 127));
      pos = POS_W'($urandom_range(0, 63));
    end
    queue_render(code, pos, len);
  endfunction

  function automatic bit glyph_complete(int unsigned code);
    for (int unsigned row = 0; row < ROWS; row++)
      if (!row_loaded[code * ROWS + row]) return 1'b0;
    return 1'b1;
  endfunction

  // only fully loaded glyphs may be rendered
  function automatic logic [CODE_W-1:0] pick_loaded_code();
    logic [CODE_W-1:0] ready [$];
    for (int unsigned c = 0; c < 256; c++)
      if (glyph_complete(c)) ready.push_back(CODE_W'(c));
    return ready[$urandom_range(0, ready.size() - 1)];
  endfunction

  function automatic void queue_glyph(logic [CODE_W-1:0] code);
    for (int unsigned row = 0; row < ROWS; row++)
      queue_load(ADDR_W'(code * ROWS + row), GLYPH_W'($urandom));
  endfunction

  // wait until every beat went in and every expected word came out
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || words_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_color(logic idx, logic [COLOR_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_INK_COLOR) ink_color = val;
    else paper_color = val;
  endtask

  // one phase of random traffic: glyph load then render, renders of known glyphs, stray loads
  task automatic random_phase();
    int unsigned      n;
    int unsigned      sel;
    logic [CODE_W-1:0] code;
    n = 0;
    while (n < PHASE_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        code = CODE_W'($urandom);
        queue_glyph(code);
        queue_random_render(code);
        n += ROWS + 1;
      end else if (sel < 8) begin
        queue_random_render(pick_loaded_code());
        n++;
      end else begin
        queue_load(ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), GLYPH_W'($urandom));
        n++;
      end
    end
  endtask

  // reset once, at the start
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // main sequence
  initial begin
    logic [GLYPH_W-1:0] edge_rows [8];
    edge_rows = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'hC3, 8'h3C};
    @(posedge rst_ni);
    @(negedge clk_i);

    // directed: top code with extreme row patterns, code zero with walking bits
    for (int unsigned row = 0; row < ROWS; row++)
      queue_load(ADDR_W'(255 * ROWS + row), row < 8 ? edge_rows[row] : GLYPH_W'($urandom));
    for (int unsigned row = 0; row < ROWS; row++)
      queue_load(ADDR_W'(row), 8'h01 << (row % 8));
    // reset colours: smallest and largest strings, zero length, the largest
    // length the field holds, position past the string end
    queue_render(8'd0,   6'd0,  7'd1);
    queue_render(8'd255, 6'd63, 7'd64);
    queue_render(8'd255, 6'd0,  7'd0);
    queue_render(8'd0,   6'd63, 7'd127);
    queue_render(8'd255, 6'd40, 7'd10);
    queue_render(8'd0,   6'd5,  7'd64);
    random_phase();
    settle();

    // inverted colours, no idling on either side
    write_color(REG_INK_COLOR, 16'h0000);
    write_color(REG_PAPER_COLOR, 16'hFFFF);
    @(negedge clk_i);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    queue_render(8'd255, 6'd1, 7'd2);
    random_phase();
    settle();

    // random colours; sender streams while the receiver holds off for a long stretch
    write_color(REG_INK_COLOR, COLOR_W'($urandom));
    write_color(REG_PAPER_COLOR, COLOR_W'($urandom));
    @(negedge clk_i);
    rx_calm = 1'b0;
    random_phase();
    hold_arm = 1'b1;
    settle();

    // same colour for both, random idling on both sides
    write_color(REG_INK_COLOR, 16'hFFFF);
    write_color(REG_PAPER_COLOR, 16'hFFFF);
    @(negedge clk_i);
    tx_calm = 1'b0;
    random_phase();
    settle();

    // random colours again, receiver never stalls
    write_color(REG_PAPER_COLOR, COLOR_W'($urandom));
    write_color(REG_INK_COLOR, COLOR_W'($urandom));
    @(negedge clk_i);
    rx_calm = 1'b1;
    random_phase();
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/gfe_pkg.sv
sv/gfe_ram.sv
sv/gfe_ctrl.sv
sv/gfe_datapath.sv
sv/glyph_to_framebuffer_expander_core.sv
dv/tb_glyph_to_framebuffer_expander_core.sv
